[design/tcf_pkg.sv]
`timescale 1ns / 1ps

package tcf_pkg;

	// Widths of the angle, the tangent, the divider quotient, the wide datapath and the level count.
	localparam int DATA_W       = 32;
	localparam int QUO_W        = 32;
	localparam int WIDE_W       = 64;
	localparam int TERM_COUNT_W = 4;

	// The odd constant of a level sits at this binary point (Q3.28 times Q15.16).
	localparam int FRAC_SHIFT = 44;

	// Default depth of the fraction and the reset level count.
	localparam int MAX_TERMS_DEF = 13;
	localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RESET = 4'd10;

	// Register index of the level count on the configuration port.
	localparam logic [0:0] REG_TERM_COUNT = 1'b0;

	// Saturation limits of the Q15.16 tangent.
	localparam logic [DATA_W-1:0] T_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] T_MIN = 32'h8000_0000;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIFF,
		ST_CHECK,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

endpackage

[design/tangent_continued_fraction.sv]
`timescale 1ns / 1ps

// Tangent of a Q3.28 angle in radians, given as a saturated Q15.16 value, by
// evaluating the continued fraction t = x / ((2i-1) - x*t) from the deepest
// level back to the first. The level count is taken from term_count, with
// zero read as one and anything above MAX_TERMS read as MAX_TERMS. Each level
// runs one multiply, one subtract for the divisor, one range check and a
// 32-step restoring division through a single shared 64-bit subtractor,
// followed by a fix-up step that applies sign and saturation. A level whose
// divisor is no larger than the angle saturates at once and skips the
// division. The block takes no new angle until the result is in the output
// register; a result that waits there does not hold back the next angle.
module tangent_continued_fraction
	import tcf_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [DATA_W-1:0]   angle,
	// Output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [DATA_W-1:0]   tangent,
	output logic                       saturated,
	// Configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int LW = $clog2(MAX_TERMS + 1);
	localparam int CW = (LW > TERM_COUNT_W) ? LW : TERM_COUNT_W;
	localparam int CNT_W = $clog2(QUO_W);
	localparam logic [CW-1:0] MAX_EXT = CW'(MAX_TERMS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

	state_t state_q, state_d;

	logic [TERM_COUNT_W-1:0] term_count_q;
	logic signed [DATA_W-1:0] x_q;
	logic [DATA_W-1:0]        t_q;
	logic                     sat_q;
	logic [LW-1:0]            lvl_q;
	logic signed [WIDE_W-1:0] p_q;
	logic [WIDE_W-1:0]        dabs_q;
	logic                     neg_q;
	logic [WIDE_W-1:0]        rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        tangent_q;
	logic                     saturated_q;

	logic [CW-1:0]     tc_ext;
	logic [LW-1:0]     lvl_first;
	logic [LW:0]       odd;
	logic [WIDE_W-1:0] odd_ext;
	logic [DATA_W-1:0] xabs;
	logic [WIDE_W-1:0] rem_shift;
	logic [WIDE_W-1:0] sub_a, sub_b;
	logic [WIDE_W:0]   sub_r;
	logic [WIDE_W-1:0] d_val;
	logic [WIDE_W-1:0] d_abs;
	logic              in_take;
	logic              out_load;
	logic              cfg_wr;
	logic              last_level;

	// Configuration port: one register, always ready.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2:2] == REG_TERM_COUNT) ? 32'(term_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RESET;
		end else if (cfg_wr && (paddr[2:2] == REG_TERM_COUNT)) begin
			term_count_q <= pwdata[TERM_COUNT_W-1:0];
		end
	end

	// Level count clamped to the range the fraction supports.
	assign tc_ext = CW'(term_count_q);
	assign lvl_first = (tc_ext == '0)     ? LW'(1) :
	                   (tc_ext > MAX_EXT) ? LW'(MAX_TERMS) : LW'(tc_ext);

	// Odd constant of the current level, placed at the Q.44 binary point.
	assign odd = {lvl_q, 1'b0} - (LW + 1)'(1);
	assign odd_ext = WIDE_W'(odd) << FRAC_SHIFT;

	assign xabs = x_q[DATA_W-1] ? (DATA_W'(0) - DATA_W'(x_q)) : DATA_W'(x_q);
	assign rem_shift = {rem_q[WIDE_W-2:0], 1'b0};

	// The shared subtractor forms the divisor and does each division step.
	always_comb begin
		case (state_q)
			ST_DIFF: begin
				sub_a = odd_ext;
				sub_b = p_q;
			end
			default: begin
				sub_a = rem_shift;
				sub_b = dabs_q;
			end
		endcase
		sub_r = {1'b0, sub_a} - {1'b0, sub_b};
	end

	assign d_val = sub_r[WIDE_W-1:0];
	assign d_abs = d_val[WIDE_W-1] ? (WIDE_W'(0) - d_val) : d_val;

	assign in_take = in_valid && !in_stall;
	assign last_level = (lvl_q == LW'(1));

	// Sequencer: next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (dabs_q <= WIDE_W'(xabs)) begin
					state_d = last_level ? ST_DONE : ST_MUL;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = last_level ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Level counter and the saturation flag of the running transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			sat_q <= 1'b0;
		end else begin
			if (in_take) begin
				lvl_q <= lvl_first;
				sat_q <= 1'b0;
			end else if ((state_q == ST_CHECK) && (dabs_q <= WIDE_W'(xabs))) begin
				sat_q <= 1'b1;
				if (!last_level) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end else if (state_q == ST_FIX) begin
				if (neg_q ? (quo_q > T_MIN) : quo_q[QUO_W-1]) begin
					sat_q <= 1'b1;
				end
				if (!last_level) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
		end
	end

	// Datapath: product, divisor, restoring division and the running tangent.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x_q <= angle;
					t_q <= '0;
				end
			end
			ST_MUL: begin
				p_q <= x_q * $signed(t_q);
			end
			ST_DIFF: begin
				dabs_q <= d_abs;
				neg_q  <= x_q[DATA_W-1] ^ d_val[WIDE_W-1];
			end
			ST_CHECK: begin
				if (dabs_q <= WIDE_W'(xabs)) begin
					t_q <= neg_q ? T_MIN : T_MAX;
				end else begin
					rem_q <= WIDE_W'(xabs);
					quo_q <= '0;
					cnt_q <= '0;
				end
			end
			ST_DIV: begin
				if (!sub_r[WIDE_W]) begin
					rem_q <= sub_r[WIDE_W-1:0];
				end else begin
					rem_q <= rem_shift;
				end
				quo_q <= {quo_q[QUO_W-2:0], !sub_r[WIDE_W]};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_FIX: begin
				if (neg_q) begin
					t_q <= (quo_q > T_MIN) ? T_MIN : (DATA_W'(0) - quo_q);
				end else begin
					t_q <= quo_q[QUO_W-1] ? T_MAX : quo_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: a waiting result does not block the next angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			tangent_q   <= t_q;
			saturated_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign tangent   = $signed(tangent_q);
	assign saturated = saturated_q;

	// The level counter stays inside the clamped range while a transaction runs.
	a_level_range : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_DONE) |->
			(lvl_q != '0 && lvl_q <= LW'(MAX_TERMS)))
		else $error("level counter outside the clamped range");

	// The division runs exactly one quotient width of steps before the fix-up.
	a_div_length : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_FIX))
		else $error("division did not end after the last quotient bit");

	// A finished division leaves a remainder below the divisor.
	a_rem_bound : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> (rem_q < dabs_q))
		else $error("division remainder not below the divisor");

	// A new angle starts at the clamped level count.
	a_start_level : assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_MUL && lvl_q == $past(lvl_first)))
		else $error("transaction started at the wrong level");

endmodule

[tb/tangent_continued_fraction_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the tangent block. It keeps
// its own copy of the level count, predicts the tangent of every accepted angle
// and compares each accepted result with the oldest prediction still waiting.
module tangent_continued_fraction_checker
	import tcf_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [DATA_W-1:0] angle,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DATA_W-1:0] tangent,
	input  logic                     saturated,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	input  logic [31:0]              prdata,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     sat;
	} tangent_result_t;

	tangent_result_t           tangent_q[$];
	logic [TERM_COUNT_W-1:0]   level_count = TERM_COUNT_RESET;
	int                        mismatches  = 0;

	assign fail_count = mismatches;

	// Evaluates the fraction from the deepest level back to the first. The product
	// and the divisor are held exactly in Q.44, the quotient is truncated towards
	// zero and every level saturates to the Q15.16 range on its own.
	function automatic tangent_result_t predict_tangent(
		input logic signed [DATA_W-1:0]   x_in,
		input logic [TERM_COUNT_W-1:0]    count
	);
		logic signed [WIDE_W-1:0] x;
		logic signed [WIDE_W-1:0] t;
		logic signed [WIDE_W-1:0] prod;
		logic signed [WIDE_W-1:0] divisor;
		logic signed [WIDE_W-1:0] odd;
		logic [WIDE_W-1:0]        x_mag;
		logic [WIDE_W-1:0]        d_mag;
		logic [WIDE_W-1:0]        quo;
		logic                     negative;
		int                       depth;
		tangent_result_t          res;
		x       = x_in;
		t       = '0;
		res.sat = 1'b0;
		depth   = count;
		// A count of zero still runs one level, and the depth is capped.
		if (depth < 1)
			depth = 1;
		if (depth > MAX_TERMS)
			depth = MAX_TERMS;
		for (int i = depth; i > 0; i--) begin
			odd     = 2 * i - 1;
			prod    = x * t;
			divisor = (odd <<< FRAC_SHIFT) - prod;
			if (divisor == 0) begin
				// A zero divisor sends the tangent to the limit on the side of the angle.
				res.sat = 1'b1;
				t = (x > 0) ? $signed(T_MAX) : $signed(T_MIN);
			end else begin
				x_mag    = (x < 0) ? -x : x;
				d_mag    = (divisor < 0) ? -divisor : divisor;
				quo      = (x_mag << 32) / d_mag;
				negative = (x < 0) != (divisor < 0);
				if (negative) begin
					if (quo > 64'h8000_0000) begin
						res.sat = 1'b1;
						t = $signed(T_MIN);
					end else begin
						t = -$signed(quo);
					end
				end else if (quo > 64'h7FFF_FFFF) begin
					res.sat = 1'b1;
					t = $signed(T_MAX);
				end else begin
					t = $signed(quo);
				end
			end
		end
		res.value = t[DATA_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tangent_result_t due;
		if (!arst_n) begin
			tangent_q.delete();
			level_count = TERM_COUNT_RESET;
			pending <= 0;
		end else begin
			// Configuration port: follow writes of the level count, check its reads.
			if (psel && penable && pready && paddr[2:2] == REG_TERM_COUNT) begin
				if (pwrite) begin
					level_count = pwdata[TERM_COUNT_W-1:0];
				end else if (prdata !== 32'(level_count)) begin
					mismatches++;
					$display("%0t level count read: expected %0d, got %0d",
						$time, level_count, prdata);
				end
			end

			// Results are matched against the oldest prediction first.
			if (out_valid && !out_stall) begin
				if (tangent_q.size() == 0) begin
					mismatches++;
					$display("%0t result with no transaction waiting: expected none, got %h/%b",
						$time, tangent, saturated);
				end else begin
					due = tangent_q.pop_front();
					if (tangent !== due.value) begin
						mismatches++;
						$display("%0t tangent: expected %h, got %h", $time, due.value, tangent);
					end
					if (saturated !== due.sat) begin
						mismatches++;
						$display("%0t saturated: expected %b, got %b", $time, due.sat, saturated);
					end
				end
			end

			// Every accepted angle queues one predicted result.
			if (in_valid && !in_stall)
				tangent_q.push_back(predict_tangent(angle, level_count));

			pending <= tangent_q.size();
		end
	end

endmodule

[tb/tangent_continued_fraction_tb.sv]
`timescale 1ns / 1ps

// Drives angles and level counts into the tangent block and gives the verdict.
// All prediction and comparison is done by the checker beside the block.
module tangent_continued_fraction_tb;
	import tcf_pkg::*;

	localparam int                       MAX_LEVELS = MAX_TERMS_DEF;
	localparam int                       PHASE_ITEMS = 100;
	localparam logic [0:0]               REG_SPARE  = 1'b1;
	localparam logic signed [DATA_W-1:0] PI_HALF    = 32'sh1921_FB54;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] angle     = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] tangent;
	logic                     saturated;
	logic                     psel      = 1'b0;
	logic                     penable   = 1'b0;
	logic                     pwrite    = 1'b0;
	logic [2:0]               paddr     = '0;
	logic [31:0]              pwdata    = '0;
	logic [31:0]              prdata;
	logic                     pready;
	int                       fail_count;
	int                       pending;

	// Level counts of the random phases, and the idling of each phase kind.
	int level_plan [12] = '{0, 15, 1, 13, 14, 2, 6, 10, 3, 9, 5, 12};
	int send_plan  [4]  = '{0, 59, 0, 20};
	int stall_plan [4]  = '{0, 0, 59, 20};
	int send_idle_pct   = 0;
	int stall_pct       = 0;

	tangent_continued_fraction #(
		.MAX_TERMS(MAX_LEVELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.angle    (angle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tangent  (tangent),
		.saturated(saturated),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	tangent_continued_fraction_checker #(
		.MAX_TERMS(MAX_LEVELS)
	) tangent_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.angle     (angle),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tangent   (tangent),
		.saturated (saturated),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// The receiver stalls at random, independently of the output valid.
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Offers one angle, after a random gap, and holds it until it is taken.
	task automatic send_angle(input logic signed [DATA_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		angle    <= value;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops offering angles until every transaction has delivered its result.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [0:0] index,
		input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {index, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_idling(input int kind);
		send_idle_pct = send_plan[kind];
		stall_pct     = stall_plan[kind];
	endtask

	// Full-range angles half of the time, with small angles and angles close to the poles
	// of the tangent, where the fraction saturates.
	function automatic logic signed [DATA_W-1:0] random_angle();
		int                       pick;
		int                       odd_pole;
		logic signed [DATA_W-1:0] offset;
		pick = $urandom_range(9);
		if (pick < 5)
			return $urandom;
		if (pick < 7)
			return $signed($urandom) >>> $urandom_range(31);
		odd_pole = 2 * $urandom_range(5) - 5;
		offset   = $signed($urandom) >>> $urandom_range(31, 11);
		return odd_pole * PI_HALF + offset;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed angles under the reset level count.
		apb_access(1'b0, REG_TERM_COUNT, '0);
		set_idling(3);
		send_angle(32'sh0000_0000);
		send_angle(32'sh0000_0001);
		send_angle(-32'sh0000_0001);
		send_angle(32'sh7FFF_FFFF);
		send_angle(32'sh8000_0000);
		send_angle(32'sh1000_0000);
		send_angle(32'shF000_0000);
		send_angle(32'sh0C90_FDAA);
		send_angle(-32'sh0C90_FDAA);
		send_angle(PI_HALF);
		send_angle(PI_HALF - 1);
		send_angle(PI_HALF + 1);
		send_angle(-PI_HALF);
		send_angle(32'sh3243_F6A9);
		send_angle(32'sh2000_0000);
		send_angle(32'shD000_0000);
		send_angle(32'sh5555_5555);
		send_angle(32'shAAAA_AAAA);
		send_angle(32'sh0001_0000);

		// Random phases, each with its own level count and one of four idling kinds.
		for (int ph = 0; ph < 12; ph++) begin
			wait_drained();
			set_idling(ph % 4);
			apb_access(1'b1, REG_TERM_COUNT, ($urandom & ~32'hF) | 32'(level_plan[ph]));
			if (ph % 4 == 1)
				apb_access(1'b1, REG_SPARE, $urandom);
			apb_access(1'b0, REG_TERM_COUNT, '0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2 && ph % 3 == 0)
					wait_drained();
				send_angle(random_angle());
			end
		end

		wait_drained();
		repeat (MAX_LEVELS * 40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#80_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
